@@ rtl/core/srde_pkg.sv @@
// Shared types and constants for the sample record delta encoder.
package srde_pkg;

   localparam logic [1:0] KIND_LATER = 2'd0;
   localparam logic [1:0] KIND_FIRST = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      MARK_NONE     = 2'd0,
      MARK_SAME     = 2'd1,
      MARK_EXPLICIT = 2'd2
   } mark_type;

   typedef struct packed {
      logic        is_empty;
      logic        is_first;
      mark_type    mark;
      logic [63:0] zz_ref;
      logic [63:0] zz_ts;
      logic [63:0] zz_st;
      logic [63:0] value;
   } job_type;

   function automatic logic [63:0] zigzag(input logic [63:0] v);
      zigzag = {v[62:0], 1'b0} ^ {64{v[63]}};
   endfunction

endpackage

@@ rtl/core/srde_serial.sv @@
// Byte sequencer: walks the fields of one encoded sample and drives the result register.
module srde_serial (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          type_code,
   input  logic                job_valid,
   input  srde_pkg::job_type   job,
   output logic                job_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte
);

   typedef enum logic [2:0] {
      SEG_TYPE,
      SEG_REF,
      SEG_TS,
      SEG_MARK,
      SEG_ST,
      SEG_VALUE
   } seg_type;

   seg_type           seg_ff, seg_in;
   logic              busy_ff, busy_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              empty_ff, empty_in;
   logic              first_ff, first_in;
   srde_pkg::mark_type mark_ff, mark_in;
   logic [63:0]       ref_ff, ref_in;
   logic [63:0]       ts_ff, ts_in;
   logic [63:0]       st_ff, st_in;
   logic [63:0]       value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              adv;
   logic              more;
   logic [7:0]        byte_out;
   logic              byte_last;
   logic              seg_done;
   seg_type           seg_next;

   assign adv = busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      more      = 1'b0;
      byte_out  = 8'd0;
      byte_last = 1'b0;
      seg_done  = 1'b1;
      seg_next  = SEG_VALUE;
      unique case (seg_ff)
         SEG_TYPE: begin
            byte_out  = type_code;
            byte_last = empty_ff;
            seg_next  = SEG_REF;
         end
         SEG_REF: begin
            more     = |ref_ff[63:7];
            byte_out = {more, ref_ff[6:0]};
            seg_done = !more;
            seg_next = SEG_TS;
         end
         SEG_TS: begin
            more     = |ts_ff[63:7];
            byte_out = {more, ts_ff[6:0]};
            seg_done = !more;
            seg_next = first_ff ? SEG_ST : SEG_MARK;
         end
         SEG_MARK: begin
            byte_out = {6'd0, mark_ff};
            seg_next = (mark_ff == srde_pkg::MARK_EXPLICIT) ? SEG_ST : SEG_VALUE;
         end
         SEG_ST: begin
            more     = |st_ff[63:7];
            byte_out = {more, st_ff[6:0]};
            seg_done = !more;
            seg_next = SEG_VALUE;
         end
         SEG_VALUE: begin
            byte_out  = value_ff[63:56];
            byte_last = (cnt_ff == 3'd7);
            seg_done  = byte_last;
         end
         default: begin
            byte_last = 1'b1;
         end
      endcase
   end

   assign job_ready = !busy_ff || (adv && byte_last);

   always_comb begin
      seg_in       = seg_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      empty_in     = empty_ff;
      first_in     = first_ff;
      mark_in      = mark_ff;
      ref_in       = ref_ff;
      ts_in        = ts_ff;
      st_in        = st_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = byte_out;
         rsp_last_in  = byte_last;
         if (byte_last) begin
            busy_in = 1'b0;
         end else if (seg_done) begin
            seg_in = seg_next;
            cnt_in = 3'd0;
         end else begin
            unique case (seg_ff)
               SEG_REF:   ref_in   = {7'd0, ref_ff[63:7]};
               SEG_TS:    ts_in    = {7'd0, ts_ff[63:7]};
               SEG_ST:    st_in    = {7'd0, st_ff[63:7]};
               SEG_VALUE: begin
                  value_in = {value_ff[55:0], 8'd0};
                  cnt_in   = cnt_ff + 3'd1;
               end
               default: cnt_in = cnt_ff;
            endcase
         end
      end

      if (job_valid && job_ready) begin
         busy_in  = 1'b1;
         seg_in   = (job.is_first || job.is_empty) ? SEG_TYPE : SEG_REF;
         cnt_in   = 3'd0;
         empty_in = job.is_empty;
         first_in = job.is_first;
         mark_in  = job.mark;
         ref_in   = job.zz_ref;
         ts_in    = job.zz_ts;
         st_in    = job.zz_st;
         value_in = job.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= SEG_TYPE;
         cnt_ff       <= 3'd0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_ff       <= seg_in;
         cnt_ff       <= cnt_in;
      end
      empty_ff    <= empty_in;
      first_ff    <= first_in;
      mark_ff     <= mark_in;
      ref_ff      <= ref_in;
      ts_ff       <= ts_in;
      st_ff       <= st_in;
      value_ff    <= value_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

@@ rtl/core/sample_record_delta_encoder.sv @@
// Top level of the sample record delta encoder: delta state, field encoding, byte output.
//
// Takes one sample per request on req_* and returns the bytes of its record on
// rsp_*, one byte per response, with rsp_last_byte high on the final byte.
// First samples emit the type byte and zigzag varints of reference, timestamp
// and start time, then the value big-endian; later samples emit deltas and a
// start-time marker; empty records emit the type byte alone. Kind 3 is
// accepted and dropped. csr_write_* sets the type byte; write it only while idle.
// An accepted request is registered in the sequencer, and each of its bytes then passes
// through the single output register to rsp_*. The sequencer emits one byte per cycle
// while the receiver takes them, and a record is 1 to 39 bytes. The next request is
// accepted in the cycle the current one's last byte enters the output register.
// A stalled receiver holds the output register and the sequencer; req_ready
// then stays low while a request is in progress. Reset clears the delta state, the
// type byte, the sequencer's busy flag and the response valid flag.
module sample_record_delta_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [63:0]        req_series_ref,
   input  logic signed [63:0] req_timestamp,
   input  logic signed [63:0] req_start_time,
   input  logic [63:0]        req_value_bits,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_byte
);

   logic [7:0]  type_code_ff, type_code_in;
   logic [63:0] first_ts_ff, first_ts_in;
   logic [63:0] first_st_ff, first_st_in;
   logic [63:0] prev_ref_ff, prev_ref_in;
   logic [63:0] prev_st_ff, prev_st_in;

   logic              accept;
   logic              is_first;
   logic              is_later;
   logic              is_empty;
   logic [63:0]       ts_u;
   logic [63:0]       st_u;
   logic [63:0]       ref_val;
   logic [63:0]       ts_val;
   logic [63:0]       st_val;
   srde_pkg::job_type job;
   logic              job_ready;

   assign accept   = req_valid && req_ready;
   assign is_first = (req_kind == srde_pkg::KIND_FIRST);
   assign is_later = (req_kind == srde_pkg::KIND_LATER);
   assign is_empty = (req_kind == srde_pkg::KIND_EMPTY);
   assign ts_u     = $unsigned(req_timestamp);
   assign st_u     = $unsigned(req_start_time);

   assign ref_val = is_first ? req_series_ref : req_series_ref - prev_ref_ff;
   assign ts_val  = is_first ? ts_u : ts_u - first_ts_ff;
   assign st_val  = is_first ? st_u : st_u - first_st_ff;

   always_comb begin
      job.is_empty = is_empty;
      job.is_first = is_first;
      priority if (st_u == 64'd0) begin
         job.mark = srde_pkg::MARK_NONE;
      end else if (st_u == prev_st_ff) begin
         job.mark = srde_pkg::MARK_SAME;
      end else begin
         job.mark = srde_pkg::MARK_EXPLICIT;
      end
      job.zz_ref = srde_pkg::zigzag(ref_val);
      job.zz_ts  = srde_pkg::zigzag(ts_val);
      job.zz_st  = srde_pkg::zigzag(st_val);
      job.value  = req_value_bits;
   end

   always_comb begin
      type_code_in = csr_write_en ? csr_write_data : type_code_ff;
      first_ts_in  = first_ts_ff;
      first_st_in  = first_st_ff;
      prev_ref_in  = prev_ref_ff;
      prev_st_in   = prev_st_ff;
      if (accept && (is_first || is_later)) begin
         prev_ref_in = req_series_ref;
         prev_st_in  = st_u;
         if (is_first) begin
            first_ts_in = ts_u;
            first_st_in = st_u;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_code_ff <= 8'd0;
         first_ts_ff  <= 64'd0;
         first_st_ff  <= 64'd0;
         prev_ref_ff  <= 64'd0;
         prev_st_ff   <= 64'd0;
      end else begin
         type_code_ff <= type_code_in;
         first_ts_ff  <= first_ts_in;
         first_st_ff  <= first_st_in;
         prev_ref_ff  <= prev_ref_in;
         prev_st_ff   <= prev_st_in;
      end
   end

   assign req_ready = job_ready;

   srde_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .type_code     (type_code_ff),
      .job_valid     (req_valid && (is_first || is_later || is_empty)),
      .job           (job),
      .job_ready     (job_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the sample record delta encoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [63:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          STALL_LIMIT  = 2000;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] series_ref;
      logic [63:0] timestamp;
      logic [63:0] start_time;
      logic [63:0] value_bits;
   } sample_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } record_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [7:0]         csr_write_data = 8'd0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = 2'd0;
   logic [63:0]        req_series_ref = 64'd0;
   logic signed [63:0] req_timestamp = 64'sd0;
   logic signed [63:0] req_start_time = 64'sd0;
   logic [63:0]        req_value_bits = 64'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last_byte;

   sample_item_type pending_samples[$];
   record_byte_type expected_bytes[$];
   logic [7:0]      record_bytes[$];

   logic [7:0]  type_code = 8'd0;
   logic [63:0] base_timestamp = 64'd0;
   logic [63:0] base_start_time = 64'd0;
   logic [63:0] prior_ref = 64'd0;
   logic [63:0] prior_start_time = 64'd0;

   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              samples_queued = 0;
   int              samples_accepted = 0;
   int              quiet_cycles = 0;
   int              failures = 0;
   logic            req_taken = 1'b0;
   sample_item_type next_sample;
   record_byte_type want;

   sample_record_delta_encoder DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_series_ref (req_series_ref),
      .req_timestamp  (req_timestamp),
      .req_start_time (req_start_time),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_record_byte(input logic [7:0] b);
      record_bytes.insert(record_bytes.size(), b);
   endfunction

   function automatic void push_varint(input logic [63:0] v);
      logic [63:0] zz;
      zz = v[63] ? ~(v << 1) : (v << 1);
      while (zz >= 64'h80) begin
         add_record_byte({1'b1, zz[6:0]});
         zz = zz >> 7;
      end
      add_record_byte({1'b0, zz[6:0]});
   endfunction

   function automatic void push_be64(input logic [63:0] v);
      for (int k = 7; k >= 0; k--) begin
         add_record_byte(v[k*8 +: 8]);
      end
   endfunction

   function automatic void encode_sample(input sample_item_type s);
      int n;
      record_bytes.delete();
      case (s.kind)
         srde_pkg::KIND_EMPTY: begin
            add_record_byte(type_code);
         end
         srde_pkg::KIND_FIRST: begin
            add_record_byte(type_code);
            push_varint(s.series_ref);
            push_varint(s.timestamp);
            push_varint(s.start_time);
            push_be64(s.value_bits);
            base_timestamp = s.timestamp;
            base_start_time = s.start_time;
            prior_ref = s.series_ref;
            prior_start_time = s.start_time;
         end
         srde_pkg::KIND_LATER: begin
            push_varint(s.series_ref - prior_ref);
            push_varint(s.timestamp - base_timestamp);
            if (s.start_time == 64'd0) begin
               add_record_byte({6'd0, srde_pkg::MARK_NONE});
            end else if (s.start_time == prior_start_time) begin
               add_record_byte({6'd0, srde_pkg::MARK_SAME});
            end else begin
               add_record_byte({6'd0, srde_pkg::MARK_EXPLICIT});
               push_varint(s.start_time - base_start_time);
            end
            push_be64(s.value_bits);
            prior_ref = s.series_ref;
            prior_start_time = s.start_time;
         end
         default: begin
         end
      endcase
      n = record_bytes.size();
      for (int i = 0; i < n; i++) begin
         expected_bytes.insert(expected_bytes.size(),
                               record_byte_type'{record_bytes[i], 1'(i == n - 1)});
      end
   endfunction

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(3) != 0) begin
         w = w >> $urandom_range(63);
         if ($urandom_range(1) == 1) begin
            w = -w;
         end
      end
      return w;
   endfunction

   task automatic queue_sample(input logic [1:0] kind, input logic [63:0] series_ref,
                               input logic [63:0] timestamp, input logic [63:0] start_time,
                               input logic [63:0] value_bits);
      pending_samples.insert(pending_samples.size(),
         sample_item_type'{kind, series_ref, timestamp, start_time, value_bits});
      samples_queued++;
   endtask

   task automatic queue_random(input int target);
      int          made;
      int          later_count;
      logic [63:0] ref_now;
      logic [63:0] ts_base;
      logic [63:0] st_base;
      logic [63:0] st_last;
      logic [63:0] st_now;
      made = 0;
      while (made < target) begin
         case ($urandom_range(9))
            0: begin
               queue_sample(srde_pkg::KIND_EMPTY, rand_word(), rand_word(), rand_word(),
                            rand_word());
               made++;
            end
            1: begin
               queue_sample(KIND_UNUSED, rand_word(), rand_word(), rand_word(), rand_word());
            end
            2: begin
               queue_sample(srde_pkg::KIND_LATER, rand_word(), rand_word(), rand_word(),
                            rand_word());
               made++;
            end
            default: begin
               ref_now = rand_word();
               ts_base = rand_word();
               st_base = ($urandom_range(3) == 0) ? 64'd0 : rand_word();
               st_last = st_base;
               queue_sample(srde_pkg::KIND_FIRST, ref_now, ts_base, st_base, rand_word());
               made++;
               later_count = $urandom_range(6);
               repeat (later_count) begin
                  ref_now = ref_now + (rand_word() >> $urandom_range(63, 40));
                  case ($urandom_range(7))
                     0, 1: st_now = 64'd0;
                     2, 3: st_now = st_last;
                     4:    st_now = st_base;
                     default: st_now = st_base + rand_word();
                  endcase
                  queue_sample(srde_pkg::KIND_LATER, ref_now,
                               ts_base + (rand_word() >> $urandom_range(63, 30)),
                               st_now, rand_word());
                  st_last = st_now;
                  made++;
               end
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (samples_accepted != samples_queued || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_type_code(input logic [7:0] code);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= code;
      @(negedge clock);
      csr_write_en <= 1'b0;
      type_code = code;
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_sample = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_kind <= next_sample.kind;
            req_series_ref <= next_sample.series_ref;
            req_timestamp <= next_sample.timestamp;
            req_start_time <= next_sample.start_time;
            req_value_bits <= next_sample.value_bits;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Request and response monitor
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            samples_accepted++;
            encode_sample(sample_item_type'{req_kind, req_series_ref, req_timestamp,
                                            req_start_time, req_value_bits});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected response: out_byte %h last_byte %b",
                      rsp_out_byte, rsp_last_byte);
               failures++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %h, actual %h", want.data, rsp_out_byte);
                  failures++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte: expected %b, actual %b", want.last, rsp_last_byte);
                  failures++;
               end
            end
         end
         if (req_taken || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("sample_record_delta_encoder regression: fail");
      $finish;
   end

   initial begin
      send_idle_pct = 8;
      recv_stall_pct = 79;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // later samples against the cleared state
      queue_sample(srde_pkg::KIND_LATER, 64'd0, 64'd0, 64'd0, 64'd0);
      queue_sample(srde_pkg::KIND_LATER, ALL_ONES, S64_MIN, S64_MAX, ALL_ONES);
      queue_sample(srde_pkg::KIND_EMPTY, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      queue_sample(KIND_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      // longest record
      queue_sample(srde_pkg::KIND_FIRST, S64_MAX, S64_MIN, S64_MAX, ALL_ONES);
      queue_sample(srde_pkg::KIND_LATER, S64_MAX, S64_MIN, S64_MAX, 64'd0);
      queue_sample(srde_pkg::KIND_LATER, 64'd0, S64_MAX, 64'd0, 64'h0123_4567_89AB_CDEF);
      queue_sample(srde_pkg::KIND_LATER, S64_MIN, 64'd0, S64_MIN, 64'd0);
      queue_sample(srde_pkg::KIND_LATER, S64_MIN, 64'd0, S64_MIN, ALL_ONES);
      queue_sample(srde_pkg::KIND_LATER, 64'd1, 64'd1, S64_MAX, 64'hFEDC_BA98_7654_3210);
      // empty and undefined requests leave the state alone
      queue_sample(srde_pkg::KIND_EMPTY, 64'd0, 64'd0, 64'd0, 64'd0);
      queue_sample(KIND_UNUSED, 64'd0, 64'd0, 64'd0, 64'd0);
      queue_sample(srde_pkg::KIND_LATER, 64'd2, 64'd2, S64_MAX, 64'd1);
      queue_sample(srde_pkg::KIND_FIRST, 64'd0, 64'd0, 64'd0, 64'd0);
      queue_sample(srde_pkg::KIND_LATER, 64'd0, 64'd0, 64'd0, ALL_ONES);
      queue_sample(srde_pkg::KIND_FIRST, ALL_ONES, 64'd1, ALL_ONES, S64_MIN);
      queue_sample(srde_pkg::KIND_LATER, 64'd0, 64'd64, ALL_ONES, S64_MAX);
      queue_sample(srde_pkg::KIND_LATER, 64'd64, 64'd65, 64'd63, 64'h8000_0000_0000_0001);
      queue_sample(srde_pkg::KIND_LATER, 64'd0, S64_MIN, ALL_ONES, 64'h5555_5555_5555_5555);
      queue_sample(srde_pkg::KIND_LATER, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFC0, 64'd1,
                   64'hAAAA_AAAA_AAAA_AAAA);
      wait_drained();

      write_type_code(8'hFF);
      queue_random(42);
      wait_drained();

      write_type_code(8'($urandom_range(254, 1)));
      send_idle_pct = 79;
      recv_stall_pct = 8;
      queue_random(42);
      wait_drained();

      write_type_code(8'h00);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random(42);
      wait_drained();

      if (failures == 0 && expected_bytes.size() == 0) begin
         $display("sample_record_delta_encoder regression: pass");
      end else begin
         $display("sample_record_delta_encoder regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/srde_pkg.sv
rtl/core/srde_serial.sv
rtl/core/sample_record_delta_encoder.sv
tb/sv/tb_top.sv
